FILE: rtl/smooth_weighted_round_robin_defines.svh
// Assertion macros shared by the smooth weighted round-robin RTL.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef SMOOTH_WEIGHTED_ROUND_ROBIN_DEFINES_SVH
`define SMOOTH_WEIGHTED_ROUND_ROBIN_DEFINES_SVH

// Condition must hold on every clock edge out of reset.
`define SWRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SWRR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/swrr_pkg.sv
// Shared types and constants for the smooth weighted round-robin selector.
// No dependencies; used by the store, the sequencer and the top.
package swrr_pkg;

  // Fixed field widths
  localparam int MODE_W   = 1;
  localparam int TARGET_W = 4;
  localparam int WEIGHT_W = 16;
  localparam int STATUS_W = 1;
  localparam int CHOSEN_W = 4;
  localparam int COUNT_W  = 5;

  // Running weight and total widths, saturation bounds
  localparam int RUN_W     = 22;
  localparam int TOTAL_W   = 21;
  localparam int RUN_MAX   = 2097151;
  localparam int RUN_MIN   = -2097152;
  localparam int TOTAL_MAX = 2097151;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PICK  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [TARGET_W-1:0] target;
    logic [WEIGHT_W-1:0] weight;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHOSEN_W-1:0] chosen;
  } rsp_t;

  // Strobes from the sequencer to the state store
  typedef struct packed {
    logic rd_en;
    logic wt_we;
    logic run_we;
    logic run_clr;
  } store_ctrl_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_WRD  = 7'b0000010,
    ST_WCMP = 7'b0000100,
    ST_SUM  = 7'b0001000,
    ST_WALK = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

endpackage

FILE: rtl/swrr_if.sv
// Valid/ready channel carrying one request or response payload.
// Payload type is set per instance, normally from swrr_pkg.
interface swrr_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/swrr_store.sv
// Weight and running-weight memories with registered reads.
// Per-entry valid bits make unwritten or cleared entries read as zero; uses swrr_pkg.
module swrr_store #(
  parameter int  MAX_ENDPOINTS = 16,
  parameter int  WEIGHT_BITS   = 16,
  localparam int IDX_W         = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1,
  localparam int RUN_W         = swrr_pkg::RUN_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swrr_pkg::store_ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0]              rd_addr_i,
  input  logic [IDX_W-1:0]              wt_waddr_i,
  input  logic [WEIGHT_BITS-1:0]        wt_wdata_i,
  input  logic [IDX_W-1:0]              run_waddr_i,
  input  logic signed [RUN_W-1:0]       run_wdata_i,
  output logic [WEIGHT_BITS-1:0]        wt_rdata_o,
  output logic signed [RUN_W-1:0]       run_rdata_o
);

  logic [WEIGHT_BITS-1:0]  wt_mem  [MAX_ENDPOINTS];
  logic signed [RUN_W-1:0] run_mem [MAX_ENDPOINTS];

  logic [WEIGHT_BITS-1:0]   wt_rd_q;
  logic signed [RUN_W-1:0]  run_rd_q;
  logic                     wt_rv_q, run_rv_q;
  logic [MAX_ENDPOINTS-1:0] wt_vld_q, wt_vld_d;
  logic [MAX_ENDPOINTS-1:0] run_vld_q, run_vld_d;

  // Memory arrays: writes and registered reads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wt_we) begin
      wt_mem[wt_waddr_i] <= wt_wdata_i;
    end
    if (ctrl_i.run_we) begin
      run_mem[run_waddr_i] <= run_wdata_i;
    end
    if (ctrl_i.rd_en) begin
      wt_rd_q  <= wt_mem[rd_addr_i];
      run_rd_q <= run_mem[rd_addr_i];
    end
  end

  // Valid bits: clear wipes all running weights at once
  always_comb begin
    wt_vld_d  = wt_vld_q;
    run_vld_d = run_vld_q;
    if (ctrl_i.wt_we) begin
      wt_vld_d[wt_waddr_i] = 1'b1;
    end
    if (ctrl_i.run_clr) begin
      run_vld_d = '0;
    end
    if (ctrl_i.run_we) begin
      run_vld_d[run_waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_vld_q  <= '0;
      run_vld_q <= '0;
      wt_rv_q   <= 1'b0;
      run_rv_q  <= 1'b0;
    end else begin
      wt_vld_q  <= wt_vld_d;
      run_vld_q <= run_vld_d;
      if (ctrl_i.rd_en) begin
        wt_rv_q  <= wt_vld_q[rd_addr_i];
        run_rv_q <= run_vld_q[rd_addr_i];
      end
    end
  end

  assign wt_rdata_o  = wt_rv_q  ? wt_rd_q  : '0;
  assign run_rdata_o = run_rv_q ? run_rd_q : '0;

endmodule

FILE: rtl/swrr_seq.sv
// Request sequencer: weight-write compare, total sweep, pick walk and winner update.
// Drives swrr_store through swrr_pkg::store_ctrl_t; uses the shared assertion macros.
`include "smooth_weighted_round_robin_defines.svh"

module swrr_seq #(
  parameter int  MAX_ENDPOINTS = 16,
  parameter int  WEIGHT_BITS   = 16,
  localparam int IDX_W         = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1,
  localparam int RUN_W         = swrr_pkg::RUN_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swrr_pkg::COUNT_W-1:0]        cfg_wdata_i,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  swrr_pkg::req_t                      req_data_i,
  output logic                                done_valid_o,
  input  logic                                done_ready_i,
  output swrr_pkg::rsp_t                      done_data_o,
  output swrr_pkg::store_ctrl_t               st_ctrl_o,
  output logic [IDX_W-1:0]                    rd_addr_o,
  output logic [IDX_W-1:0]                    wt_waddr_o,
  output logic [WEIGHT_BITS-1:0]              wt_wdata_o,
  output logic [IDX_W-1:0]                    run_waddr_o,
  output logic signed [RUN_W-1:0]             run_wdata_o,
  input  logic [WEIGHT_BITS-1:0]              wt_rdata_i,
  input  logic signed [RUN_W-1:0]             run_rdata_i
);

  localparam int CNT_W   = $clog2(MAX_ENDPOINTS + 1);
  localparam int TOTAL_W = swrr_pkg::TOTAL_W;
  // compare widths for count, target, weight and chosen
  localparam int CMP_W   = (CNT_W > swrr_pkg::COUNT_W) ? CNT_W : swrr_pkg::COUNT_W;
  localparam int TGT_W   = (CNT_W > swrr_pkg::TARGET_W) ? CNT_W : swrr_pkg::TARGET_W;
  localparam int WX_W    = (WEIGHT_BITS > swrr_pkg::WEIGHT_W) ? WEIGHT_BITS
                                                             : swrr_pkg::WEIGHT_W;
  localparam int CH_W    = (IDX_W > swrr_pkg::CHOSEN_W) ? IDX_W : swrr_pkg::CHOSEN_W;
  // adder widths
  localparam int AW = ((RUN_W > WEIGHT_BITS + 1) ? RUN_W : WEIGHT_BITS + 1) + 1;
  localparam int DW = RUN_W + 1;
  localparam int ZW = ((TOTAL_W > WEIGHT_BITS) ? TOTAL_W : WEIGHT_BITS) + 1;

  localparam logic signed [AW-1:0] RUN_HI_A = AW'(swrr_pkg::RUN_MAX);
  localparam logic signed [AW-1:0] RUN_LO_A = AW'(swrr_pkg::RUN_MIN);
  localparam logic signed [DW-1:0] RUN_LO_D = DW'(swrr_pkg::RUN_MIN);
  localparam logic [ZW-1:0]        TOT_HI_Z = ZW'(swrr_pkg::TOTAL_MAX);

  swrr_pkg::state_e        state_q, state_d;
  logic [CNT_W-1:0]        n_q, n_d;
  logic [TOTAL_W-1:0]      total_q, total_d;
  logic [CNT_W-1:0]        rd_cnt_q, rd_cnt_d;
  logic                    p_vld_q, p_vld_d;
  logic                    rsp_flag_q, rsp_flag_d;

  logic [IDX_W-1:0]        tgt_q, tgt_d;
  logic [WEIGHT_BITS-1:0]  w_q, w_d;
  logic [TOTAL_W-1:0]      acc_q, acc_d;
  logic signed [RUN_W-1:0] best_val_q, best_val_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [IDX_W-1:0]        p_idx_q, p_idx_d;
  swrr_pkg::rsp_t          res_q, res_d;

  logic                    issue, sweep_end, accept, better;
  logic [CMP_W-1:0]        cnt_ext, cnt_sat;
  logic [CNT_W-1:0]        cnt_new;
  logic [TGT_W-1:0]        tgt_ext;
  logic                    tgt_ok;
  logic [WX_W-1:0]         w_ext;
  logic [CH_W-1:0]         ch_ext;
  logic signed [AW-1:0]    walk_sum;
  logic signed [RUN_W-1:0] walk_new;
  logic signed [DW-1:0]    fin_diff;
  logic signed [RUN_W-1:0] fin_val;
  logic [ZW-1:0]           acc_sum;
  logic [TOTAL_W-1:0]      acc_new;

  // Decode of the incoming count and request fields
  assign cnt_ext = CMP_W'(cfg_wdata_i);
  assign cnt_sat = (cnt_ext > CMP_W'(MAX_ENDPOINTS)) ? CMP_W'(MAX_ENDPOINTS) : cnt_ext;
  assign cnt_new = cnt_sat[CNT_W-1:0];
  assign tgt_ext = TGT_W'(req_data_i.target);
  assign tgt_ok  = tgt_ext < TGT_W'(MAX_ENDPOINTS);
  assign w_ext   = WX_W'(req_data_i.weight);
  assign ch_ext  = CH_W'(best_idx_q);

  assign req_ready_o = (state_q == swrr_pkg::ST_IDLE) && !cfg_we_i;
  assign accept      = req_valid_i && req_ready_o;

  // Sweep pipeline: address issued the cycle before its data returns
  assign issue     = ((state_q == swrr_pkg::ST_SUM) || (state_q == swrr_pkg::ST_WALK))
                     && (rd_cnt_q < n_q);
  assign sweep_end = !issue && !p_vld_q;

  // Running weight plus weight, saturated
  assign walk_sum = $signed({{(AW-RUN_W){run_rdata_i[RUN_W-1]}}, run_rdata_i})
                  + $signed({{(AW-WEIGHT_BITS){1'b0}}, wt_rdata_i});
  assign walk_new = (walk_sum > RUN_HI_A) ? RUN_HI_A[RUN_W-1:0] :
                    (walk_sum < RUN_LO_A) ? RUN_LO_A[RUN_W-1:0] : walk_sum[RUN_W-1:0];
  assign better   = (p_idx_q == '0) || (walk_new > best_val_q);

  // Winner minus total; the total is never negative, so only the floor applies
  assign fin_diff = $signed({best_val_q[RUN_W-1], best_val_q})
                  - $signed({{(DW-TOTAL_W){1'b0}}, total_q});
  assign fin_val  = (fin_diff < RUN_LO_D) ? RUN_LO_D[RUN_W-1:0] : fin_diff[RUN_W-1:0];

  // Total accumulation, saturated
  assign acc_sum = {{(ZW-TOTAL_W){1'b0}}, acc_q} + {{(ZW-WEIGHT_BITS){1'b0}}, wt_rdata_i};
  assign acc_new = (acc_sum > TOT_HI_Z) ? TOT_HI_Z[TOTAL_W-1:0] : acc_sum[TOTAL_W-1:0];

  assign done_valid_o = (state_q == swrr_pkg::ST_DONE);
  assign done_data_o  = res_q;
  assign wt_waddr_o   = tgt_q;
  assign wt_wdata_o   = w_q;

  // Next-state and memory control
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    total_d    = total_q;
    rd_cnt_d   = rd_cnt_q;
    p_vld_d    = issue;
    rsp_flag_d = rsp_flag_q;
    tgt_d      = tgt_q;
    w_d        = w_q;
    acc_d      = acc_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    p_idx_d    = p_idx_q;
    res_d      = res_q;

    st_ctrl_o       = '0;
    st_ctrl_o.rd_en = issue;
    rd_addr_o       = rd_cnt_q[IDX_W-1:0];
    run_waddr_o     = p_idx_q;
    run_wdata_o     = walk_new;

    if (issue) begin
      rd_cnt_d = rd_cnt_q + CNT_W'(1);
      p_idx_d  = rd_cnt_q[IDX_W-1:0];
    end

    case (state_q)
      swrr_pkg::ST_IDLE: begin
        if (cfg_we_i) begin
          // count change resizes the list: clear running weights, redo total
          if (cnt_new != n_q) begin
            n_d               = cnt_new;
            st_ctrl_o.run_clr = 1'b1;
            rd_cnt_d          = '0;
            acc_d             = '0;
            rsp_flag_d        = 1'b0;
            state_d           = swrr_pkg::ST_SUM;
          end
        end else if (accept) begin
          tgt_d = tgt_ext[IDX_W-1:0];
          w_d   = w_ext[WEIGHT_BITS-1:0];
          res_d = '{status: swrr_pkg::STATUS_OK, chosen: '0};
          if (req_data_i.mode == swrr_pkg::MODE_WRITE) begin
            state_d = tgt_ok ? swrr_pkg::ST_WRD : swrr_pkg::ST_DONE;
          end else if (n_q == '0) begin
            res_d.status = swrr_pkg::STATUS_EMPTY;
            state_d      = swrr_pkg::ST_DONE;
          end else begin
            rd_cnt_d = '0;
            state_d  = swrr_pkg::ST_WALK;
          end
        end
      end

      swrr_pkg::ST_WRD: begin
        st_ctrl_o.rd_en = 1'b1;
        rd_addr_o       = tgt_q;
        state_d         = swrr_pkg::ST_WCMP;
      end

      swrr_pkg::ST_WCMP: begin
        if (wt_rdata_i != w_q) begin
          st_ctrl_o.wt_we   = 1'b1;
          st_ctrl_o.run_clr = 1'b1;
          rd_cnt_d          = '0;
          acc_d             = '0;
          rsp_flag_d        = 1'b1;
          state_d           = swrr_pkg::ST_SUM;
        end else begin
          state_d = swrr_pkg::ST_DONE;
        end
      end

      swrr_pkg::ST_SUM: begin
        if (p_vld_q) begin
          acc_d = acc_new;
        end
        if (sweep_end) begin
          total_d = acc_q;
          state_d = rsp_flag_q ? swrr_pkg::ST_DONE : swrr_pkg::ST_IDLE;
        end
      end

      swrr_pkg::ST_WALK: begin
        if (p_vld_q) begin
          st_ctrl_o.run_we = 1'b1;
          if (better) begin
            best_val_d = walk_new;
            best_idx_d = p_idx_q;
          end
        end
        if (sweep_end) begin
          state_d = swrr_pkg::ST_FIN;
        end
      end

      swrr_pkg::ST_FIN: begin
        st_ctrl_o.run_we = 1'b1;
        run_waddr_o      = best_idx_q;
        run_wdata_o      = fin_val;
        res_d            = '{status: swrr_pkg::STATUS_OK,
                             chosen: ch_ext[swrr_pkg::CHOSEN_W-1:0]};
        state_d          = swrr_pkg::ST_DONE;
      end

      swrr_pkg::ST_DONE: begin
        if (done_ready_i) begin
          state_d = swrr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = swrr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= swrr_pkg::ST_IDLE;
      n_q        <= '0;
      total_q    <= '0;
      rd_cnt_q   <= '0;
      p_vld_q    <= 1'b0;
      rsp_flag_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      total_q    <= total_d;
      rd_cnt_q   <= rd_cnt_d;
      p_vld_q    <= p_vld_d;
      rsp_flag_q <= rsp_flag_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tgt_q      <= tgt_d;
    w_q        <= w_d;
    acc_q      <= acc_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    p_idx_q    <= p_idx_d;
    res_q      <= res_d;
  end

  // Walk reads entry k+1 while writing back entry k
  `SWRR_ASSERT_IMPL(a_rw_distinct, st_ctrl_o.rd_en && st_ctrl_o.run_we, rd_addr_o != run_waddr_o, "read and write-back hit the same entry")
  // A clear never coincides with a running-weight access
  `SWRR_ASSERT_IMPL(a_clr_alone, st_ctrl_o.run_clr, !st_ctrl_o.run_we && !st_ctrl_o.rd_en, "clear overlaps a memory access")
  // Winner update is followed directly by the response
  `SWRR_ASSERT_NEXT(a_fin_done, state_q == swrr_pkg::ST_FIN, state_q == swrr_pkg::ST_DONE, "winner update not followed by response")
  // A walk only runs over a non-empty list
  `SWRR_ASSERT(a_walk_nonempty, (state_q != swrr_pkg::ST_WALK) || (n_q != '0), "walk with no active targets")

endmodule

FILE: rtl/smooth_weighted_round_robin.sv
// Pick with n active targets: the walk reads one running weight per cycle through the
// single memory read port, then updates the winner; no new request is taken until the
// result leaves the sequencer. Pick with no active targets: empty status, no walk. Weight
// write: an unchanged weight is only compared; a changed one is written and the total
// re-summed; a count change blocks requests during a re-sum. Async reset clears count,
// total and per-entry valid bits, so both memories read as zero at once; no clearing pass.
module smooth_weighted_round_robin #(
  parameter int MAX_ENDPOINTS = 16,
  parameter int WEIGHT_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [swrr_pkg::COUNT_W-1:0] cfg_wdata_i,
  swrr_if.sink                         req_i,
  swrr_if.source                       rsp_o
);

  localparam int IDX_W = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
  localparam int RUN_W = swrr_pkg::RUN_W;

  swrr_pkg::store_ctrl_t   st_ctrl;
  logic [IDX_W-1:0]        rd_addr, wt_waddr, run_waddr;
  logic [WEIGHT_BITS-1:0]  wt_wdata, wt_rdata;
  logic signed [RUN_W-1:0] run_wdata, run_rdata;

  logic                    done_valid, done_ready, load;
  swrr_pkg::rsp_t          done_data;
  logic                    rsp_vld_q, rsp_vld_d;
  swrr_pkg::rsp_t          rsp_q;

  swrr_seq #(
    .MAX_ENDPOINTS (MAX_ENDPOINTS),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_data_i   (req_i.data),
    .done_valid_o (done_valid),
    .done_ready_i (done_ready),
    .done_data_o  (done_data),
    .st_ctrl_o    (st_ctrl),
    .rd_addr_o    (rd_addr),
    .wt_waddr_o   (wt_waddr),
    .wt_wdata_o   (wt_wdata),
    .run_waddr_o  (run_waddr),
    .run_wdata_o  (run_wdata),
    .wt_rdata_i   (wt_rdata),
    .run_rdata_i  (run_rdata)
  );

  swrr_store #(
    .MAX_ENDPOINTS (MAX_ENDPOINTS),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (st_ctrl),
    .rd_addr_i   (rd_addr),
    .wt_waddr_i  (wt_waddr),
    .wt_wdata_i  (wt_wdata),
    .run_waddr_i (run_waddr),
    .run_wdata_i (run_wdata),
    .wt_rdata_o  (wt_rdata),
    .run_rdata_o (run_rdata)
  );

  // Output register: takes a new result when empty or being drained
  assign done_ready = !rsp_vld_q || rsp_o.ready;
  assign load       = done_valid && done_ready;

  always_comb begin
    rsp_vld_d = rsp_vld_q;
    if (load) begin
      rsp_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q <= done_data;
    end
  end

  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

endmodule
